/* rtl/core/msdt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdt_pkg
// Shared types and constants of the multi-drive stepper tone generator.
// ----------------------------------------------------------------------------
package msdt_pkg;

  localparam int MAX_DRIVES  = 16;
  localparam int PERIOD_W    = 16;
  localparam int CHAN_W      = 4;
  localparam int CMD_W       = 2;
  localparam int MAP_W       = 24;
  localparam int TRACK_W     = 7;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_W        = 24;
  localparam int IN_USER_W   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MAP_W-1:0]    CHMAP_RESET   = 24'h323210;
  localparam logic [PERIOD_W-1:0] MINP_RESET    = 16'd101;
  localparam logic [PERIOD_W-1:0] HOMEINT_RESET = 16'd40;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PERIOD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HOME   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_CHMAP   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MINP    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOMEINT = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_HOME,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic [MAX_DRIVES-1:0]     mask;
    logic [PERIOD_W-1:0]       period;
  } op_t;

endpackage : msdt_pkg
`default_nettype wire

/* rtl/core/multi_drive_stepper_tone_generator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_drive_stepper_tone_generator_top
// Stepper drives used as tone sources, with period commands and homing.
//
//   port group | dir | contents
//   in_*       | in  | tuser: command; tdata: channel, period
//   out_*      | out | tdata: step_pulses, directions, active_leds, homing
//   cfg_*      | in  | write: channel_map, min_period, homing_interval
//
// One transfer per cycle in each direction while neither side stalls; decode
// writes each accepted input into the queue, and the drive engine takes it from
// the queue head into its output register, from which its result is sent.
// The two-entry queue and the output register let either side stall alone.
// Reset starts the homing sequence; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_drive_stepper_tone_generator_top #(
  parameter int DRIVES = 6,
  parameter int TRACKS = 80
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [3:0] channel, [19:4] period
  input  wire logic [msdt_pkg::IN_W-1:0]           in_tdata,
  // [1:0] command
  input  wire logic [msdt_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // step_pulses, directions, active_leds (DRIVES bits each), then homing
  output logic [((3*DRIVES+8)/8)*8-1:0]            out_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [msdt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [msdt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import msdt_pkg::*;

  localparam int OUT_W = ((3 * DRIVES + 8) / 8) * 8;

  logic [MAP_W-1:0]    chmap_r;
  logic [PERIOD_W-1:0] minp_r;
  logic [PERIOD_W-1:0] homeint_r;

  logic              q_push, q_pop, q_full, q_valid;
  op_t               push_op, head_op;
  logic [DRIVES-1:0] pulses, dirs, leds;
  logic              homing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chmap_r   <= CHMAP_RESET;
      minp_r    <= MINP_RESET;
      homeint_r <= HOMEINT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CHMAP:   chmap_r   <= cfg_wdata[MAP_W-1:0];
        CFG_MINP:    minp_r    <= cfg_wdata[PERIOD_W-1:0];
        CFG_HOMEINT: homeint_r <= cfg_wdata[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  msdt_front #(
    .DRIVES(DRIVES)
  ) u_front (
    .in_valid    (in_tvalid),
    .in_command  (in_tuser[CMD_W-1:0]),
    .in_channel  (in_tdata[CHAN_W-1:0]),
    .in_period   (in_tdata[CHAN_W +: PERIOD_W]),
    .channel_map (chmap_r),
    .min_period  (minp_r),
    .q_full      (q_full),
    .in_ready    (in_tready),
    .q_push      (q_push),
    .q_op        (push_op)
  );

  msdt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head_op (head_op)
  );

  msdt_back #(
    .DRIVES(DRIVES),
    .TRACKS(TRACKS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (head_op),
    .homing_interval (homeint_r),
    .out_ready       (out_tready),
    .q_pop           (q_pop),
    .out_valid       (out_tvalid),
    .out_step_pulses (pulses),
    .out_directions  (dirs),
    .out_active_leds (leds),
    .out_homing      (homing)
  );

  assign out_tdata = OUT_W'({homing, leds, dirs, pulses});

endmodule : multi_drive_stepper_tone_generator_top
`default_nettype wire

/* rtl/core/msdt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdt_front
// Decodes commands, checks periods against the minimum and resolves the
// channel map into a drive mask.
// ----------------------------------------------------------------------------
module msdt_front #(
  parameter int DRIVES = 6
) (
  input  wire logic                            in_valid,
  input  wire logic [msdt_pkg::CMD_W-1:0]      in_command,
  input  wire logic [msdt_pkg::CHAN_W-1:0]     in_channel,
  input  wire logic [msdt_pkg::PERIOD_W-1:0]   in_period,
  input  wire logic [msdt_pkg::MAP_W-1:0]      channel_map,
  input  wire logic [msdt_pkg::PERIOD_W-1:0]   min_period,
  input  wire logic                            q_full,
  output logic                                 in_ready,
  output logic                                 q_push,
  output msdt_pkg::op_t                        q_op
);
  import msdt_pkg::*;

  logic [CHAN_W-1:0] map_shift [DRIVES];
  logic              period_ok;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign period_ok = (in_period == '0) || (in_period >= min_period);

  always_comb begin
    q_op.kind   = OP_NOP;
    q_op.mask   = '0;
    q_op.period = in_period;
    for (int i = 0; i < DRIVES; i++) begin
      // drives past the map read channel 0
      map_shift[i] = CHAN_W'(channel_map >> (4 * i));
      if (period_ok && (map_shift[i] == in_channel)) begin
        q_op.mask[i] = 1'b1;
      end
    end
    unique case (in_command)
      CMD_TICK:   q_op.kind = OP_TICK;
      CMD_PERIOD: q_op.kind = OP_SET;
      CMD_HOME:   q_op.kind = OP_HOME;
      CMD_UNUSED: q_op.kind = OP_NOP;
      default:    q_op.kind = OP_NOP;
    endcase
  end

endmodule : msdt_front
`default_nettype wire

/* rtl/core/msdt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdt_queue
// Two-entry operation queue between the decoder and the drive engine.
// ----------------------------------------------------------------------------
module msdt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire msdt_pkg::op_t push_op,
  input  wire logic          pop,
  output logic               full,
  output logic               valid,
  output msdt_pkg::op_t      head_op
);
  import msdt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign head_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule : msdt_queue
`default_nettype wire

/* rtl/core/msdt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdt_back
// Drive engine: per-drive step countdowns, direction reversal, homing
// sequence and the registered result.
// ----------------------------------------------------------------------------
module msdt_back #(
  parameter int DRIVES = 6,
  parameter int TRACKS = 80
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire msdt_pkg::op_t                   q_op,
  input  wire logic [msdt_pkg::PERIOD_W-1:0]   homing_interval,
  input  wire logic                            out_ready,
  output logic                                 q_pop,
  output logic                                 out_valid,
  output logic [DRIVES-1:0]                    out_step_pulses,
  output logic [DRIVES-1:0]                    out_directions,
  output logic [DRIVES-1:0]                    out_active_leds,
  output logic                                 out_homing
);
  import msdt_pkg::*;

  localparam logic [TRACK_W-1:0] REV_RELOAD = TRACK_W'(TRACKS - 1);
  localparam logic [TRACK_W-1:0] HOME_STEPS = TRACK_W'(TRACKS);

  logic [PERIOD_W-1:0] period_r [DRIVES];
  logic [PERIOD_W-1:0] period_nxt [DRIVES];
  logic [PERIOD_W-1:0] ticks_r [DRIVES];
  logic [PERIOD_W-1:0] ticks_nxt [DRIVES];
  logic [PERIOD_W-1:0] ticks_dec [DRIVES];
  logic [TRACK_W-1:0]  rev_r [DRIVES];
  logic [TRACK_W-1:0]  rev_nxt [DRIVES];
  logic [TRACK_W-1:0]  rev_dec [DRIVES];
  logic [DRIVES-1:0]   dir_r, dir_nxt;
  logic [TRACK_W-1:0]  hleft_r, hleft_nxt;
  logic [PERIOD_W-1:0] hcnt_r, hcnt_nxt, hcnt_dec;
  logic [DRIVES-1:0]   pulses, leds;

  logic                out_valid_r, out_valid_nxt;
  logic [DRIVES-1:0]   pulses_r, dirs_r, leds_r;
  logic                homing_r;

  assign q_pop           = q_valid && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_step_pulses = pulses_r;
  assign out_directions  = dirs_r;
  assign out_active_leds = leds_r;
  assign out_homing      = homing_r;
  assign hcnt_dec        = hcnt_r - 1'b1;

  always_comb begin
    period_nxt = period_r;
    ticks_nxt  = ticks_r;
    rev_nxt    = rev_r;
    dir_nxt    = dir_r;
    hleft_nxt  = hleft_r;
    hcnt_nxt   = hcnt_r;
    pulses     = '0;
    leds       = '0;
    for (int i = 0; i < DRIVES; i++) begin
      ticks_dec[i] = ticks_r[i] - 1'b1;
      rev_dec[i]   = rev_r[i] - 1'b1;
    end
    if (q_pop) begin
      unique case (q_op.kind)
        OP_TICK: begin
          if (hleft_r != '0) begin
            if (hcnt_dec == '0) begin
              pulses    = '1;
              hcnt_nxt  = homing_interval;
              hleft_nxt = hleft_r - 1'b1;
              if (hleft_r == TRACK_W'(1)) begin
                dir_nxt = '0;
              end
            end else begin
              hcnt_nxt = hcnt_dec;
            end
          end else begin
            for (int i = 0; i < DRIVES; i++) begin
              if (period_r[i] != '0) begin
                if (ticks_dec[i] == '0) begin
                  pulses[i]    = 1'b1;
                  ticks_nxt[i] = period_r[i];
                  if (rev_dec[i] == '0) begin
                    dir_nxt[i] = ~dir_r[i];
                    rev_nxt[i] = REV_RELOAD;
                  end else begin
                    rev_nxt[i] = rev_dec[i];
                  end
                end else begin
                  ticks_nxt[i] = ticks_dec[i];
                end
              end
            end
          end
        end
        OP_SET: begin
          for (int i = 0; i < DRIVES; i++) begin
            if (q_op.mask[i]) begin
              period_nxt[i] = q_op.period;
            end
          end
        end
        OP_HOME: begin
          for (int i = 0; i < DRIVES; i++) begin
            period_nxt[i] = '0;
            rev_nxt[i]    = REV_RELOAD;
          end
          dir_nxt   = '1;
          hleft_nxt = HOME_STEPS;
          hcnt_nxt  = homing_interval;
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
    for (int i = 0; i < DRIVES; i++) begin
      leds[i] = (period_nxt[i] != '0);
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DRIVES; i++) begin
        period_r[i] <= '0;
        ticks_r[i]  <= PERIOD_W'(1);
        rev_r[i]    <= REV_RELOAD;
      end
      dir_r       <= '1;
      hleft_r     <= HOME_STEPS;
      hcnt_r      <= HOMEINT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      ticks_r     <= ticks_nxt;
      rev_r       <= rev_nxt;
      dir_r       <= dir_nxt;
      hleft_r     <= hleft_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pulses_r <= pulses;
      dirs_r   <= dir_nxt;
      leds_r   <= leds;
      homing_r <= (hleft_nxt != '0);
    end
  end

endmodule : msdt_back
`default_nettype wire
